// File: rtl/utc_pkg.sv
// ----------------------------------------------------------------------------
// utc_pkg
// Types, codes and the byte expansion function of the UTF-16 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package utc_pkg;

  // Target encoding codes. Codes 5 to 7 behave as UTF-8 without a BOM.
  localparam logic [2:0] ENC_ASCII     = 3'd0;
  localparam logic [2:0] ENC_UTF8      = 3'd1;
  localparam logic [2:0] ENC_UTF8_BOM  = 3'd2;
  localparam logic [2:0] ENC_UTF16LE   = 3'd3;
  localparam logic [2:0] ENC_UTF16BE   = 3'd4;

  // Newline style codes. Code 3 behaves as LF.
  localparam logic [1:0] NL_CRLF = 2'd0;
  localparam logic [1:0] NL_LF   = 2'd1;
  localparam logic [1:0] NL_CR   = 2'd2;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TARGET_ENCODING = 1'b0;
  localparam logic REG_NEWLINE_STYLE   = 1'b1;

  localparam logic [20:0] SCALAR_LF = 21'h0000A;
  localparam logic [20:0] SCALAR_CR = 21'h0000D;

  // One classified code unit, as the front end hands it to the back end.
  typedef struct packed {
    logic [2:0]  enc;
    logic [1:0]  nl;
    logic        bom;
    logic        emit;
    logic [20:0] scalar;
    logic        fault;
    logic        ends;
  } job_t;

  // All bytes of one job, first byte in entry 0.
  typedef struct packed {
    logic [5:0][7:0] bytes;
    logic [2:0]      count;
    logic            err;
  } expand_t;

  function automatic expand_t expand_job(job_t j);
    expand_t     e;
    logic [2:0]  n;
    logic        utf16;
    logic        two;
    logic [20:0] first;
    logic [20:0] cur;
    logic [19:0] a;
    logic [15:0] u0;
    logic [15:0] u1;
    logic        pair;
    e = '0;
    n = 3'd0;
    utf16 = (j.enc == ENC_UTF16LE) || (j.enc == ENC_UTF16BE);

    if (j.bom) begin
      unique case (j.enc)
        ENC_UTF8_BOM: begin
          e.bytes[0] = 8'hEF;
          e.bytes[1] = 8'hBB;
          e.bytes[2] = 8'hBF;
          n = 3'd3;
        end
        ENC_UTF16LE: begin
          e.bytes[0] = 8'hFF;
          e.bytes[1] = 8'hFE;
          n = 3'd2;
        end
        ENC_UTF16BE: begin
          e.bytes[0] = 8'hFE;
          e.bytes[1] = 8'hFF;
          n = 3'd2;
        end
        default: n = 3'd0;
      endcase
    end

    // A line feed becomes CR LF, CR or stays LF.
    two = (j.scalar == SCALAR_LF) && (j.nl == NL_CRLF);
    first = ((j.scalar == SCALAR_LF) && ((j.nl == NL_CRLF) || (j.nl == NL_CR))) ?
            SCALAR_CR : j.scalar;

    if (j.emit) begin
      for (int k = 0; k < 2; k++) begin
        if ((k == 0) || two) begin
          cur = (k == 0) ? first : SCALAR_LF;
          if (utf16) begin
            a = 20'(cur - 21'h10000);
            pair = cur > 21'h0FFFF;
            u0 = pair ? (16'hD800 | {6'b0, a[19:10]}) : cur[15:0];
            u1 = 16'hDC00 | {6'b0, a[9:0]};
            if (j.enc == ENC_UTF16LE) begin
              e.bytes[n] = u0[7:0];
              e.bytes[n + 3'd1] = u0[15:8];
            end else begin
              e.bytes[n] = u0[15:8];
              e.bytes[n + 3'd1] = u0[7:0];
            end
            n = n + 3'd2;
            if (pair) begin
              if (j.enc == ENC_UTF16LE) begin
                e.bytes[n] = u1[7:0];
                e.bytes[n + 3'd1] = u1[15:8];
              end else begin
                e.bytes[n] = u1[15:8];
                e.bytes[n + 3'd1] = u1[7:0];
              end
              n = n + 3'd2;
            end
          end else if (cur < 21'h80) begin
            e.bytes[n] = cur[7:0];
            n = n + 3'd1;
          end else if (cur < 21'h800) begin
            e.bytes[n] = {3'b110, cur[10:6]};
            e.bytes[n + 3'd1] = {2'b10, cur[5:0]};
            n = n + 3'd2;
          end else if (cur < 21'h10000) begin
            e.bytes[n] = {4'b1110, cur[15:12]};
            e.bytes[n + 3'd1] = {2'b10, cur[11:6]};
            e.bytes[n + 3'd2] = {2'b10, cur[5:0]};
            n = n + 3'd3;
          end else begin
            e.bytes[n] = {5'b11110, cur[20:18]};
            e.bytes[n + 3'd1] = {2'b10, cur[17:12]};
            e.bytes[n + 3'd2] = {2'b10, cur[11:6]};
            e.bytes[n + 3'd3] = {2'b10, cur[5:0]};
            n = n + 3'd4;
          end
        end
      end
    end

    if (j.fault) begin
      e.bytes[n] = 8'h00;
      n = n + 3'd1;
      e.err = 1'b1;
    end
    e.count = n;
    return e;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utc_front.sv
// ----------------------------------------------------------------------------
// utc_front
// Accepts code units, pairs surrogates, tracks BOM and discard state.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [15:0]     s_tdata,    // [15:0] code_unit
  input  wire logic            s_tlast,    // last_unit
  input  wire logic [2:0]      target_encoding,
  input  wire logic [1:0]      newline_style,
  input  wire logic            q_full,
  output logic                 q_push,
  output utc_pkg::job_t        q_job
);
  import utc_pkg::*;

  logic       bom_due, bom_due_next;
  logic [9:0] held_high_bits, held_high_bits_next;
  logic       have_high, have_high_next;
  logic       discarding, discarding_next;
  logic       accept;
  logic       hi, lo;
  logic       has_bytes;
  job_t       job;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;
  assign hi = (s_tdata >= 16'hD800) && (s_tdata <= 16'hDBFF);
  assign lo = (s_tdata >= 16'hDC00) && (s_tdata <= 16'hDFFF);

  always_comb begin
    bom_due_next = bom_due;
    held_high_bits_next = held_high_bits;
    have_high_next = have_high;
    discarding_next = discarding;
    job.enc = target_encoding;
    job.nl = newline_style;
    job.bom = 1'b0;
    job.emit = 1'b0;
    job.scalar = {5'b0, s_tdata};
    job.fault = 1'b0;
    job.ends = 1'b0;
    has_bytes = 1'b0;

    if (discarding) begin
      if (s_tlast) begin
        discarding_next = 1'b0;
        bom_due_next = 1'b1;
      end
    end else begin
      job.bom = bom_due;
      bom_due_next = 1'b0;
      if (have_high) begin
        have_high_next = 1'b0;
        held_high_bits_next = '0;
        if (lo) begin
          job.emit = 1'b1;
          job.scalar = 21'h10000 + {1'b0, held_high_bits, s_tdata[9:0]};
          job.ends = s_tlast;
        end else begin
          job.fault = 1'b1;
        end
      end else if (hi) begin
        if (s_tlast) begin
          job.fault = 1'b1;
        end else begin
          held_high_bits_next = s_tdata[9:0];
          have_high_next = 1'b1;
        end
      end else if (lo) begin
        job.fault = 1'b1;
      end else begin
        job.emit = 1'b1;
        job.ends = s_tlast;
      end

      if (job.fault) begin
        job.ends = 1'b1;
        if (!s_tlast) begin
          discarding_next = 1'b1;
        end
      end
      if (job.ends) begin
        if (!discarding_next) begin
          bom_due_next = 1'b1;
        end
        have_high_next = 1'b0;
        held_high_bits_next = '0;
      end
      has_bytes = job.emit || job.fault ||
                  (bom_due && ((target_encoding == ENC_UTF8_BOM) ||
                               (target_encoding == ENC_UTF16LE) ||
                               (target_encoding == ENC_UTF16BE)));
    end
  end

  assign q_push = accept && has_bytes;
  assign q_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      bom_due <= 1'b1;
      held_high_bits <= '0;
      have_high <= 1'b0;
      discarding <= 1'b0;
    end else if (accept) begin
      bom_due <= bom_due_next;
      held_high_bits <= held_high_bits_next;
      have_high <= have_high_next;
      discarding <= discarding_next;
    end
  end

  // A held high surrogate is always cleared before discarding begins.
  assert property (@(posedge clk) disable iff (rst) !(have_high && discarding))
    else $error("surrogate held while discarding");

endmodule

`default_nettype wire

// File: rtl/utc_queue.sv
// ----------------------------------------------------------------------------
// utc_queue
// Two-entry queue of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire utc_pkg::job_t push_job,
  input  wire logic          pop,
  output utc_pkg::job_t      head,
  output logic               valid,
  output logic               full
);
  import utc_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign valid = fill != 2'd0;
  assign full = fill == 2'd2;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("push into a full job queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("pop from an empty job queue");

endmodule

`default_nettype wire

// File: rtl/utc_back.sv
// ----------------------------------------------------------------------------
// utc_back
// Expands the job at the queue head into bytes and sends one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module utc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire utc_pkg::job_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,    // [7:0] out_byte
  output logic               m_tlast,    // end_of_text
  output logic [1:0]         m_tuser     // [0] end_of_run, [1] error
);
  import utc_pkg::*;

  expand_t    exp;
  logic [2:0] idx;
  logic       load;
  logic       last_byte;

  assign exp = expand_job(head);
  assign load = head_valid && (!m_tvalid || m_tready);
  assign last_byte = idx == (exp.count - 3'd1);
  assign pop = load && last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx <= 3'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx <= last_byte ? 3'd0 : idx + 3'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= exp.bytes[idx];
      m_tlast <= last_byte && head.ends;
      m_tuser <= {last_byte && exp.err, last_byte};
    end
  end

  // Every queued job carries at least one byte and the index stays inside it.
  assert property (@(posedge clk) disable iff (rst)
                   head_valid |-> (exp.count != 3'd0) && (idx < exp.count))
    else $error("byte index outside the job");

  // An error byte is always the last byte of its run and of its text.
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && m_tuser[1]) |-> (m_tuser[0] && m_tlast))
    else $error("error byte not closing the text");

endmodule

`default_nettype wire

// File: rtl/utf16_transcode_newline_convert.sv
// ----------------------------------------------------------------------------
// utf16_transcode_newline_convert
// UTF-16 to UTF-8 / UTF-16 transcoder with newline conversion.
// ----------------------------------------------------------------------------
// The slave stream takes one UTF-16 code unit per transaction, with s_tlast
// marking the last unit of a text. The master stream gives one encoded byte
// per transaction; m_tlast marks the last byte of a text, m_tuser[0] the last
// byte caused by one input unit and m_tuser[1] the single error byte of a
// text cut short by an unpaired surrogate.
// The APB port holds target_encoding at address 0 and newline_style at 4;
// both should be written only while no text is in flight.
// A unit is classified in the cycle it is accepted and queued in a two-entry
// job queue; its bytes go from the queue head through the output register to
// the master side. The back end sends one byte per cycle while the receiver
// takes them; a unit gives zero to six bytes (one to three for typical text),
// and units that give no byte are not queued. The slave side accepts a unit in
// any cycle in which the job queue has room.
// When the receiver stalls, the output register holds its byte, the queue
// fills and s_tready drops as soon as two jobs wait in it. Reset empties the
// queue, sets UTF-8 with CR LF newlines and arms the BOM for the next text.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_transcode_newline_convert (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] code_unit
  input  wire logic        s_tlast,   // last_unit
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast,   // end_of_text
  output logic [1:0]       m_tuser,   // [0] end_of_run, [1] error
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import utc_pkg::*;

  logic [2:0] target_encoding;
  logic [1:0] newline_style;
  logic       cfg_write;
  logic       q_push;
  job_t       q_job;
  job_t       q_head;
  logic       q_valid;
  logic       q_full;
  logic       q_pop;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_encoding <= ENC_UTF8;
      newline_style <= NL_CRLF;
    end else if (cfg_write) begin
      if (paddr[2] == REG_TARGET_ENCODING) begin
        target_encoding <= pwdata[2:0];
      end else begin
        newline_style <= pwdata[1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_NEWLINE_STYLE) ? {30'b0, newline_style} :
                                                    {29'b0, target_encoding};

  utc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .target_encoding (target_encoding),
    .newline_style   (newline_style),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (q_job)
  );

  utc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .valid    (q_valid),
    .full     (q_full)
  );

  utc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

`default_nettype wire

// File: test/utf16_transcode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_transcode_checker
// Predicts and checks the byte stream of the UTF-16 transcoder.
// Watches the unit stream, the byte stream and register writes at the rising
// clock edge, expands every accepted code unit into the bytes it must produce
// and compares each byte transaction field by field against the oldest one.
// ----------------------------------------------------------------------------

module utf16_transcode_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          units_used,
  output int          bytes_checked,
  output int          error_bytes
);
  import utc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       text_end;
    logic       err;
  } enc_byte_t;

  enc_byte_t expected_bytes[$];
  enc_byte_t unit_bytes[$];

  logic [2:0] enc;
  logic [1:0] nl;
  logic       bom_pending;
  logic [9:0] held_bits;
  logic       high_held;
  logic       dropping;

  function automatic void put_byte(input logic [7:0] b, input logic e);
    enc_byte_t x;
    x = '{data: b, run_end: 1'b0, text_end: 1'b0, err: e};
    unit_bytes.push_back(x);
  endfunction

  function automatic void put_unit16(input logic [15:0] v);
    if (enc == ENC_UTF16LE) begin
      put_byte(v[7:0], 1'b0);
      put_byte(v[15:8], 1'b0);
    end else begin
      put_byte(v[15:8], 1'b0);
      put_byte(v[7:0], 1'b0);
    end
  endfunction

  function automatic void put_scalar(input logic [20:0] s);
    logic [20:0] a;
    a = s - 21'h10000;
    if (enc == ENC_UTF16LE || enc == ENC_UTF16BE) begin
      if (s > 21'h0FFFF) begin
        put_unit16(16'hD800 + 16'(a >> 10));
        put_unit16(16'hDC00 + 16'(a & 21'h3FF));
      end else begin
        put_unit16(s[15:0]);
      end
    end else if (s < 21'h80) begin
      put_byte(s[7:0], 1'b0);
    end else if (s < 21'h800) begin
      put_byte(8'hC0 | 8'(s >> 6), 1'b0);
      put_byte(8'h80 | 8'(s & 21'h3F), 1'b0);
    end else if (s < 21'h10000) begin
      put_byte(8'hE0 | 8'(s >> 12), 1'b0);
      put_byte(8'h80 | 8'((s >> 6) & 21'h3F), 1'b0);
      put_byte(8'h80 | 8'(s & 21'h3F), 1'b0);
    end else begin
      put_byte(8'hF0 | 8'((s >> 18) & 21'h7), 1'b0);
      put_byte(8'h80 | 8'((s >> 12) & 21'h3F), 1'b0);
      put_byte(8'h80 | 8'((s >> 6) & 21'h3F), 1'b0);
      put_byte(8'h80 | 8'(s & 21'h3F), 1'b0);
    end
  endfunction

  function automatic void put_text_scalar(input logic [20:0] s);
    if (s == SCALAR_LF && nl == NL_CRLF) begin
      put_scalar(SCALAR_CR);
      put_scalar(SCALAR_LF);
    end else if (s == SCALAR_LF && nl == NL_CR) begin
      put_scalar(SCALAR_CR);
    end else begin
      put_scalar(s);
    end
  endfunction

  // Expands one accepted code unit into its bytes and queues them.
  function automatic void transcode_unit(input logic [15:0] cu, input logic last);
    logic      is_high;
    logic      is_low;
    logic      fault;
    logic      ends;
    enc_byte_t tail;
    is_high = (cu >= 16'hD800) && (cu <= 16'hDBFF);
    is_low = (cu >= 16'hDC00) && (cu <= 16'hDFFF);
    fault = 1'b0;
    ends = 1'b0;
    unit_bytes.delete();

    // The rest of an aborted text is swallowed up to its last unit.
    if (dropping) begin
      if (last) begin
        dropping = 1'b0;
        bom_pending = 1'b1;
      end
      return;
    end

    if (bom_pending) begin
      case (enc)
        ENC_UTF8_BOM: begin
          put_byte(8'hEF, 1'b0);
          put_byte(8'hBB, 1'b0);
          put_byte(8'hBF, 1'b0);
        end
        ENC_UTF16LE: begin
          put_byte(8'hFF, 1'b0);
          put_byte(8'hFE, 1'b0);
        end
        ENC_UTF16BE: begin
          put_byte(8'hFE, 1'b0);
          put_byte(8'hFF, 1'b0);
        end
        default: ;
      endcase
      bom_pending = 1'b0;
    end

    if (high_held) begin
      high_held = 1'b0;
      if (is_low) begin
        put_text_scalar(21'h10000 + {1'b0, held_bits, cu[9:0]});
        ends = last;
      end else begin
        fault = 1'b1;
      end
      held_bits = '0;
    end else if (is_high) begin
      if (last) begin
        fault = 1'b1;
      end else begin
        held_bits = cu[9:0];
        high_held = 1'b1;
      end
    end else if (is_low) begin
      fault = 1'b1;
    end else begin
      put_text_scalar({5'b0, cu});
      ends = last;
    end

    if (fault) begin
      put_byte(8'h00, 1'b1);
      ends = 1'b1;
      if (!last) dropping = 1'b1;
    end

    if (ends) begin
      if (!dropping) bom_pending = 1'b1;
      high_held = 1'b0;
      held_bits = '0;
    end

    if (unit_bytes.size() > 0) begin
      tail = unit_bytes.pop_back();
      tail.run_end = 1'b1;
      tail.text_end = ends;
      unit_bytes.push_back(tail);
    end
    foreach (unit_bytes[i]) expected_bytes.push_back(unit_bytes[i]);
  endfunction

  function automatic void compare_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    enc_byte_t want;
    if (rst) begin
      enc = ENC_UTF8;
      nl = NL_CRLF;
      bom_pending = 1'b1;
      held_bits = '0;
      high_held = 1'b0;
      dropping = 1'b0;
      expected_bytes.delete();
      fail_count = 0;
      units_used = 0;
      bytes_checked = 0;
      error_bytes = 0;
    end else begin
      // A unit accepted at this edge still sees the old register values.
      if (s_tvalid && s_tready) begin
        if (!dropping) units_used++;
        transcode_unit(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          fail_count++;
          $display("%0t: byte transaction with none expected, expected nothing, actual %h",
                   $time, m_tdata);
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (m_tuser[1]) error_bytes++;
          compare_field("out_byte", want.data, m_tdata);
          compare_field("end_of_run", {7'b0, want.run_end}, {7'b0, m_tuser[0]});
          compare_field("end_of_text", {7'b0, want.text_end}, {7'b0, m_tlast});
          compare_field("error", {7'b0, want.err}, {7'b0, m_tuser[1]});
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TARGET_ENCODING) enc = pwdata[2:0];
        else nl = pwdata[1:0];
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the UTF-16 transcoder with newline conversion.
// Sends directed texts for the encoding edges, BOM timing and surrogate
// faults, then random texts over four idle phases and several register
// settings, with one long receiver hold-off. A checker module predicts and
// compares every byte.
// ----------------------------------------------------------------------------

module testbench;
  import utc_pkg::*;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // [15:0] code_unit
  logic        s_tlast;   // last_unit
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [7:0] out_byte
  logic        m_tlast;   // end_of_text
  logic [1:0]  m_tuser;   // [0] end_of_run, [1] error
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int units_used;
  int bytes_checked;
  int error_bytes;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int texts_sent = 0;

  logic [15:0] text_units[$];

  utf16_transcode_newline_convert DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  utf16_transcode_checker check_transcoder (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .fail_count(fail_count), .pending(pending), .units_used(units_used),
    .bytes_checked(bytes_checked), .error_bytes(error_bytes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("FAIL utf16_transcode_newline_convert");
    $finish;
  end

  // Byte receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        m_tready = 1'b0;
        repeat (300) @(negedge clk);
      end
      m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_unit(input logic [15:0] cu, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = cu;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text();
    foreach (text_units[i]) send_unit(text_units[i], i == text_units.size() - 1);
    texts_sent++;
  endtask

  // Stops sending and waits until every expected byte has come out.
  task automatic quiesce();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_config(input logic [2:0] enc, input logic [1:0] nl);
    write_reg({REG_TARGET_ENCODING, 2'b00}, {29'b0, enc});
    write_reg({REG_NEWLINE_STYLE, 2'b00}, {30'b0, nl});
  endtask

  // Mostly well-formed text, with some broken surrogates and raw noise.
  task automatic random_text();
    int len;
    int pick;
    logic [15:0] v;
    text_units.delete();
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        v = ($urandom_range(0, 2) == 0) ? 16'h000A : 16'($urandom_range(0, 127));
        text_units.push_back(v);
      end else if (pick < 45) begin
        text_units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
      end else if (pick < 65) begin
        v = 16'($urandom_range(16'h0800, 16'hFFFF));
        if (v[15:11] == 5'b11011) v = v ^ 16'h2000;
        text_units.push_back(v);
      end else if (pick < 88) begin
        text_units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
        text_units.push_back(16'hDC00 | 16'($urandom_range(0, 1023)));
      end else if (pick < 92) begin
        text_units.push_back(16'hDC00 | 16'($urandom_range(0, 1023)));
      end else if (pick < 96) begin
        text_units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
        text_units.push_back(16'($urandom_range(0, 16'hD7FF)));
      end else begin
        text_units.push_back(16'($urandom()));
      end
    end
    if ($urandom_range(0, 19) == 0)
      text_units.push_back(16'hD800 | 16'($urandom_range(0, 1023)));
    send_text();
  endtask

  initial begin : stimulus
    int goal;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Reset settings: UTF-8 with CR LF. Byte length edges and extreme pairs.
    text_units = '{16'h0000, 16'h000A, 16'h007F, 16'h0080, 16'h07FF, 16'hFFFF,
                   16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF};
    send_text();
    quiesce();
    set_config(ENC_UTF8_BOM, NL_CR);
    // BOM goes out with a held high surrogate; then a lone low one aborts a text.
    text_units = '{16'hD83D, 16'hDE00, 16'h000A};
    send_text();
    text_units = '{16'hDC00, 16'h0042};
    send_text();
    quiesce();
    set_config(ENC_UTF16LE, NL_LF);
    // High surrogate followed by a plain unit, then one marked as last.
    text_units = '{16'h000A, 16'hD800, 16'h0041};
    send_text();
    text_units = '{16'hD800};
    send_text();
    quiesce();
    set_config(ENC_UTF16BE, 2'd3);
    text_units = '{16'h000A, 16'hD801, 16'hDC37};
    send_text();
    quiesce();
    set_config(ENC_ASCII, NL_CRLF);
    text_units = '{16'h00E9, 16'h000A};
    send_text();
    quiesce();
    set_config(3'd7, NL_CR);
    text_units = '{16'h0041, 16'h000A};
    send_text();

    for (int phase = 0; phase < 4; phase++) begin
      quiesce();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          set_config(ENC_UTF8, NL_LF);
        end
        1: begin
          send_idle_pct = 50;
          recv_stall_pct = 0;
          set_config(ENC_UTF16BE, NL_CRLF);
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 50;
          set_config(ENC_UTF16LE, NL_CR);
          // The receiver holds off while units keep coming, so the input stalls.
          hold_requests++;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct = 36;
          set_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
        end
      endcase
      goal = units_used + 22;
      while (units_used < goal) begin
        random_text();
        // Halfway through the last phase the sender waits for the output to drain.
        if (phase == 3 && units_used >= goal - 12 && units_used < goal - 4) quiesce();
      end
    end

    quiesce();
    repeat (20) @(negedge clk);
    $display("Run covered %0d texts, %0d code units in use, %0d bytes checked, %0d error bytes.",
             texts_sent, units_used, bytes_checked, error_bytes);
    $display("All target encodings incl. reserved codes, all newline styles, four idle phases.");
    if (fail_count == 0) begin
      $display("PASS utf16_transcode_newline_convert");
    end else begin
      $display("FAIL utf16_transcode_newline_convert");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/utc_pkg.sv
rtl/utc_front.sv
rtl/utc_queue.sv
rtl/utc_back.sv
rtl/utf16_transcode_newline_convert.sv
test/utf16_transcode_checker.sv
test/testbench.sv
